/* rtl/clni_pkg.sv */
// ----------------------------------------------------------------------------
// clni_pkg
// Shared types and constants for the character-LCD 4-bit nibble interface.
// ----------------------------------------------------------------------------
package clni_pkg;

  // command codes of an input beat
  localparam logic [2:0] CMD_PRINT  = 3'd0;
  localparam logic [2:0] CMD_GOTO   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_BLINK  = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;
  localparam logic [2:0] CMD_INIT   = 3'd5;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // controller command bytes
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_DISP_DEFAULT = 8'h0C;
  localparam logic [7:0] LCD_FUNC_SET     = 8'h20;
  localparam logic [7:0] LCD_FUNC_2LINE   = 8'h08;
  localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] LCD_ROW_ODD      = 8'h40;
  localparam logic [3:0] LCD_WAKE_NIB     = 4'h3;
  localparam logic [3:0] LCD_4BIT_NIB     = 4'h2;

  localparam logic [5:0] COLS_RESET = 6'd16;
  localparam logic [2:0] ROWS_RESET = 3'd2;
  localparam logic [2:0] ROWS_MAX   = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [6:0] col_in;
    logic [2:0] row_in;
    logic       flag_value;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_CHAR,
    JOB_ADDR_CHAR,
    JOB_INIT
  } job_kind_e;

  // one classified command for the back end
  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

endpackage

/* rtl/clni_queue.sv */
// ----------------------------------------------------------------------------
// clni_queue
// Two-entry job queue between the front end and the nibble sequencer.
// ----------------------------------------------------------------------------
module clni_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clni_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output clni_pkg::job_t head_o
);

  clni_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/clni_back.sv */
// ----------------------------------------------------------------------------
// clni_back
// Nibble sequencer: expands one job into bus writes, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module clni_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  clni_pkg::job_t       q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clni_pkg::out_item_t  out_data_o
);

  logic                busy_q;
  clni_pkg::job_t      job_q;
  logic [3:0]          idx_q;
  logic                out_valid_q;
  clni_pkg::out_item_t out_q;

  logic                slot_free;
  logic [3:0]          last_idx;
  logic [3:0]          nib;
  logic                rs;
  logic                is_last;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o     = !busy_q && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_last     = (idx_q == last_idx);

  always_comb begin
    last_idx = 4'd1;
    nib      = job_q.b0[7:4];
    rs       = 1'b0;
    case (job_q.kind)
      clni_pkg::JOB_CMD: begin
        last_idx = 4'd1;
        nib      = idx_q[0] ? job_q.b0[3:0] : job_q.b0[7:4];
      end
      clni_pkg::JOB_CHAR: begin
        last_idx = 4'd1;
        rs       = 1'b1;
        nib      = idx_q[0] ? job_q.b1[3:0] : job_q.b1[7:4];
      end
      clni_pkg::JOB_ADDR_CHAR: begin
        last_idx = 4'd3;
        rs       = idx_q[1];
        if (idx_q[1]) begin
          nib = idx_q[0] ? job_q.b1[3:0] : job_q.b1[7:4];
        end else begin
          nib = idx_q[0] ? job_q.b0[3:0] : job_q.b0[7:4];
        end
      end
      clni_pkg::JOB_INIT: begin
        last_idx = 4'd11;
        case (idx_q)
          4'd0, 4'd1, 4'd2: nib = clni_pkg::LCD_WAKE_NIB;
          4'd3:             nib = clni_pkg::LCD_4BIT_NIB;
          4'd4:             nib = job_q.b0[7:4];
          4'd5:             nib = job_q.b0[3:0];
          4'd6:             nib = clni_pkg::LCD_DISP_DEFAULT[7:4];
          4'd7:             nib = clni_pkg::LCD_DISP_DEFAULT[3:0];
          4'd8:             nib = clni_pkg::LCD_CLEAR[7:4];
          4'd9:             nib = clni_pkg::LCD_CLEAR[3:0];
          4'd10:            nib = clni_pkg::LCD_ENTRY_MODE[7:4];
          default:          nib = clni_pkg::LCD_ENTRY_MODE[3:0];
        endcase
      end
      default: begin
        last_idx = 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 4'd0;
      end else if (busy_q && slot_free) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (slot_free) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_head_i;
    end
    if (busy_q && slot_free) begin
      out_q.reg_select <= rs;
      out_q.nibble     <= nib;
      out_q.last       <= is_last;
    end
  end

endmodule

/* rtl/clni_front.sv */
// ----------------------------------------------------------------------------
// clni_front
// Command front end: holds config and cursor state, classifies commands,
// folds goto columns into rows with a bit-serial divider.
// ----------------------------------------------------------------------------
module clni_front #(
  parameter int MAX_COLS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clni_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output clni_pkg::job_t     push_data_o
);

  localparam logic [5:0] MaxCols = 6'(MAX_COLS);

  clni_pkg::front_state_e state_q, state_d;

  logic [5:0] columns_q;
  logic [2:0] rows_q;
  logic [5:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic [7:0] dctl_q, dctl_d;

  // divider registers
  logic [5:0] rem_q, rem_d;
  logic [6:0] quo_q, quo_d;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] trow_q, trow_d;

  logic [5:0] eff_c;
  logic [2:0] eff_r;
  logic       accept;

  logic [6:0] rem_sh;
  logic       rem_ge;

  logic [2:0] wrap_y;
  logic [1:0] wrap_row;
  logic [7:0] wrap_addr;
  logic       wrap;

  logic [7:0] goto_y;
  logic [1:0] goto_row;
  logic [7:0] goto_addr;

  always_comb begin
    eff_c = columns_q;
    if (columns_q == 6'd0) begin
      eff_c = 6'd1;
    end else if (columns_q > MaxCols) begin
      eff_c = MaxCols;
    end
    eff_r = rows_q;
    if (rows_q == 3'd0) begin
      eff_r = 3'd1;
    end else if (rows_q > clni_pkg::ROWS_MAX) begin
      eff_r = clni_pkg::ROWS_MAX;
    end
  end

  assign in_stall_o = (state_q != clni_pkg::F_IDLE) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // restoring divide step: one quotient bit a cycle
  assign rem_sh = {rem_q, quo_q[6]};
  assign rem_ge = (rem_sh >= {1'b0, eff_c});

  // print past the last column: address of the next row start
  always_comb begin
    wrap     = (col_q >= eff_c);
    wrap_y   = {1'b0, row_q} + 3'd1;
    if (wrap_y >= eff_r) begin
      wrap_y = 3'd0;
    end
    wrap_row  = wrap_y[1:0];
    wrap_addr = (wrap_row[0] ? clni_pkg::LCD_ROW_ODD : 8'd0)
              + (wrap_row[1] ? {2'b00, eff_c} : 8'd0);
  end

  // goto: quotient adds rows, remainder is the column
  always_comb begin
    goto_y   = {5'd0, trow_q} + {1'b0, quo_q};
    goto_row = (goto_y < {5'd0, eff_r}) ? goto_y[1:0] : 2'd0;
    goto_addr = (goto_row[0] ? clni_pkg::LCD_ROW_ODD : 8'd0)
              + (goto_row[1] ? {2'b00, eff_c} : 8'd0)
              + {2'b00, rem_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      clni_pkg::F_IDLE: begin
        if (accept && in_data_i.cmd == clni_pkg::CMD_GOTO) begin
          state_d = clni_pkg::F_DIV;
        end
      end
      clni_pkg::F_DIV: begin
        if (cnt_q == 3'd6) begin
          state_d = clni_pkg::F_PUSH;
        end
      end
      clni_pkg::F_PUSH: begin
        if (!q_full_i) begin
          state_d = clni_pkg::F_IDLE;
        end
      end
      default: state_d = clni_pkg::F_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    push_o           = 1'b0;
    push_data_o.kind = clni_pkg::JOB_CMD;
    push_data_o.b0   = clni_pkg::LCD_CLEAR;
    push_data_o.b1   = in_data_i.char_code;
    col_d  = col_q;
    row_d  = row_q;
    dctl_d = dctl_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    trow_d = trow_q;
    case (state_q)
      clni_pkg::F_IDLE: begin
        if (accept) begin
          case (in_data_i.cmd)
            clni_pkg::CMD_PRINT: begin
              push_o = 1'b1;
              if (wrap) begin
                push_data_o.kind = clni_pkg::JOB_ADDR_CHAR;
                push_data_o.b0   = clni_pkg::LCD_SET_DDRAM | wrap_addr;
                col_d            = 6'd1;
                row_d            = wrap_row;
              end else begin
                push_data_o.kind = clni_pkg::JOB_CHAR;
                col_d            = col_q + 6'd1;
              end
            end
            clni_pkg::CMD_GOTO: begin
              rem_d  = 6'd0;
              quo_d  = in_data_i.col_in;
              cnt_d  = 3'd0;
              trow_d = in_data_i.row_in;
            end
            clni_pkg::CMD_CLEAR: begin
              push_o = 1'b1;
            end
            clni_pkg::CMD_BLINK: begin
              push_o         = 1'b1;
              dctl_d         = {dctl_q[7:1], in_data_i.flag_value};
              push_data_o.b0 = dctl_d;
            end
            clni_pkg::CMD_CURSOR: begin
              push_o         = 1'b1;
              dctl_d         = {dctl_q[7:2], in_data_i.flag_value, dctl_q[0]};
              push_data_o.b0 = dctl_d;
            end
            clni_pkg::CMD_INIT: begin
              push_o           = 1'b1;
              push_data_o.kind = clni_pkg::JOB_INIT;
              push_data_o.b0   = clni_pkg::LCD_FUNC_SET |
                                 ((eff_r < 3'd2) ? 8'd0 : clni_pkg::LCD_FUNC_2LINE);
              col_d            = 6'd0;
              row_d            = 2'd0;
              dctl_d           = clni_pkg::LCD_DISP_DEFAULT;
            end
            default: begin
              push_o = 1'b0;
            end
          endcase
        end
      end
      clni_pkg::F_DIV: begin
        rem_d = rem_ge ? 6'(rem_sh - {1'b0, eff_c}) : rem_sh[5:0];
        quo_d = {quo_q[5:0], rem_ge};
        cnt_d = cnt_q + 3'd1;
      end
      clni_pkg::F_PUSH: begin
        push_o           = !q_full_i;
        push_data_o.kind = clni_pkg::JOB_CMD;
        push_data_o.b0   = clni_pkg::LCD_SET_DDRAM | goto_addr;
        if (!q_full_i) begin
          col_d = rem_q;
          row_d = goto_row;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= clni_pkg::F_IDLE;
      columns_q <= clni_pkg::COLS_RESET;
      rows_q    <= clni_pkg::ROWS_RESET;
      col_q     <= 6'd0;
      row_q     <= 2'd0;
      dctl_q    <= clni_pkg::LCD_DISP_DEFAULT;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      dctl_q  <= dctl_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          clni_pkg::CFG_COLUMNS: columns_q <= cfg_data_i;
          clni_pkg::CFG_ROWS:    rows_q    <= cfg_data_i[2:0];
          default:               columns_q <= columns_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    trow_q <= trow_d;
  end

endmodule

/* rtl/char_lcd_nibble_interface_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// Throughput: one nibble beat per cycle within a command while the output
// is not stalled; each job is loaded from the queue before its first beat,
// and goto stalls the input while its 7-step column divider runs. Commands
// emit 2 (clear, flags, goto, plain print), 4 (wrapping print) or 12 (init)
// beats. Reset clears cursor, sets columns 16, rows 2, control 0x0C.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_top #(
  parameter int MAX_COLS = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [5:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clni_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output clni_pkg::out_item_t out_data_o
);

  logic           push;
  clni_pkg::job_t push_data;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  clni_pkg::job_t q_head;

  clni_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  clni_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  clni_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* test/char_lcd_nibble_interface_top_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top_tb
// Drives display commands into the nibble interface and checks every bus
// beat against a cycle-free predictor of the cursor, control byte and bus
// writes. Covers init, print with line and last-row wrap, goto folding,
// clear, blink and cursor bits, undefined commands, and a sweep of column
// and row settings with random idle and stall gaps on both sides.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_top_tb;

  localparam int          LCD_MAX_COLS  = 40;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          SEG_ITEMS     = 16;
  localparam logic [2:0]  CMD_UNDEF_6   = 3'd6;
  localparam logic [2:0]  CMD_UNDEF_7   = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_idx;
  logic [5:0]          cfg_data;
  logic                in_valid;
  logic                in_stall;
  clni_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  clni_pkg::out_item_t out_data;

  // predictor state
  logic [5:0]          cols_reg;
  logic [2:0]          rows_reg;
  logic [5:0]          cur_col;
  logic [1:0]          cur_row;
  logic [7:0]          disp_ctrl;
  clni_pkg::out_item_t nib_q[$];
  int                  new_beats;

  int  errors;
  int  cmds_sent;
  int  beats_checked;
  int  cfg_writes;
  int  quiet_cycles;
  bit  gaps_on;
  clni_pkg::out_item_t want;

  char_lcd_nibble_interface_top #(
    .MAX_COLS(LCD_MAX_COLS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned used_cols();
    int unsigned c;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > LCD_MAX_COLS) c = LCD_MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned used_rows();
    int unsigned r;
    r = rows_reg;
    if (r < 1) r = 1;
    if (r > clni_pkg::ROWS_MAX) r = clni_pkg::ROWS_MAX;
    return r;
  endfunction

  function automatic void emit_nib(logic rs, logic [3:0] nib);
    clni_pkg::out_item_t b;
    b.reg_select = rs;
    b.nibble     = nib;
    b.last       = 1'b0;
    nib_q.push_back(b);
    new_beats++;
  endfunction

  function automatic void emit_byte(logic rs, logic [7:0] val);
    emit_nib(rs, val[7:4]);
    emit_nib(rs, val[3:0]);
  endfunction

  // folds column overflow into rows and sends the ddram address command
  function automatic void place_cursor(int unsigned x, int unsigned y);
    int unsigned c;
    int unsigned addr;
    c = used_cols();
    while (x > c - 1) begin
      x -= c;
      y++;
    end
    if (y > used_rows() - 1) y = 0;
    cur_col = x[5:0];
    cur_row = y[1:0];
    addr = y[0] ? int'(clni_pkg::LCD_ROW_ODD) : 0;
    while (y > 1) begin
      y -= 2;
      addr += c;
    end
    addr += x;
    emit_byte(1'b0, clni_pkg::LCD_SET_DDRAM | addr[7:0]);
  endfunction

  function automatic void predict_beats(clni_pkg::in_item_t it);
    int unsigned         y;
    clni_pkg::out_item_t b;
    new_beats = 0;
    case (it.cmd)
      clni_pkg::CMD_PRINT: begin
        if (cur_col > used_cols() - 1) begin
          y = int'(cur_row) + 1;
          if (y > used_rows() - 1) y = 0;
          place_cursor(0, y);
        end
        cur_col = cur_col + 6'd1;
        emit_byte(1'b1, it.char_code);
      end
      clni_pkg::CMD_GOTO: place_cursor(it.col_in, it.row_in);
      clni_pkg::CMD_CLEAR: emit_byte(1'b0, clni_pkg::LCD_CLEAR);
      clni_pkg::CMD_BLINK: begin
        disp_ctrl[0] = it.flag_value;
        emit_byte(1'b0, disp_ctrl);
      end
      clni_pkg::CMD_CURSOR: begin
        disp_ctrl[1] = it.flag_value;
        emit_byte(1'b0, disp_ctrl);
      end
      clni_pkg::CMD_INIT: begin
        cur_col   = '0;
        cur_row   = '0;
        disp_ctrl = clni_pkg::LCD_DISP_DEFAULT;
        emit_nib(1'b0, clni_pkg::LCD_WAKE_NIB);
        emit_nib(1'b0, clni_pkg::LCD_WAKE_NIB);
        emit_nib(1'b0, clni_pkg::LCD_WAKE_NIB);
        emit_nib(1'b0, clni_pkg::LCD_4BIT_NIB);
        emit_byte(1'b0, clni_pkg::LCD_FUNC_SET |
                        (used_rows() < 2 ? 8'h00 : clni_pkg::LCD_FUNC_2LINE));
        emit_byte(1'b0, disp_ctrl);
        emit_byte(1'b0, clni_pkg::LCD_CLEAR);
        emit_byte(1'b0, clni_pkg::LCD_ENTRY_MODE);
      end
      default: ;
    endcase
    if (new_beats > 0) begin
      b = nib_q.pop_back();
      b.last = 1'b1;
      nib_q.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic clni_pkg::in_item_t make_cmd(logic [2:0] cmd, logic [7:0] ch,
                                                  logic [6:0] col, logic [2:0] row,
                                                  logic fl);
    clni_pkg::in_item_t it;
    it.cmd        = cmd;
    it.char_code  = ch;
    it.col_in     = col;
    it.row_in     = row;
    it.flag_value = fl;
    return it;
  endfunction

  // mostly prints and gotos so the cursor walks across lines and wraps
  function automatic clni_pkg::in_item_t random_cmd();
    clni_pkg::in_item_t it;
    int unsigned        w;
    it = make_cmd(clni_pkg::CMD_PRINT, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  3'($urandom_range(7)), 1'($urandom_range(1)));
    w = $urandom_range(99);
    if (w < 50) it.cmd = clni_pkg::CMD_PRINT;
    else if (w < 68) begin
      it.cmd = clni_pkg::CMD_GOTO;
      if ($urandom_range(3) != 0) it.col_in = 7'($urandom_range(used_cols() + 1));
    end
    else if (w < 74) it.cmd = clni_pkg::CMD_CLEAR;
    else if (w < 81) it.cmd = clni_pkg::CMD_BLINK;
    else if (w < 88) it.cmd = clni_pkg::CMD_CURSOR;
    else if (w < 94) it.cmd = clni_pkg::CMD_INIT;
    else it.cmd = $urandom_range(1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_cmd(input clni_pkg::in_item_t it);
    while (gaps_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beats(it);
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic drain_beats();
    in_valid <= 1'b0;
    while (nib_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [5:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == clni_pkg::CFG_COLUMNS) cols_reg = val;
    else rows_reg = val[2:0];
    cfg_writes++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (nib_q.size() == 0) begin
        $error("unexpected beat: reg_select=%0d nibble=%h last=%0d",
               out_data.reg_select, out_data.nibble, out_data.last);
        errors++;
      end else begin
        want = nib_q.pop_front();
        if (out_data.reg_select !== want.reg_select) begin
          $error("reg_select: expected %0d, got %0d", want.reg_select, out_data.reg_select);
          errors++;
        end
        if (out_data.nibble !== want.nibble) begin
          $error("nibble: expected %h, got %h", want.nibble, out_data.nibble);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_init_sequence();
    send_cmd(make_cmd(clni_pkg::CMD_INIT, 8'h00, 7'h00, 3'd0, 1'b0));
  endtask

  task automatic test_basic_commands();
    send_cmd(make_cmd(clni_pkg::CMD_PRINT, 8'h00, 7'h00, 3'd0, 1'b0));
    send_cmd(make_cmd(clni_pkg::CMD_PRINT, 8'hFF, 7'h7F, 3'd7, 1'b1));
    send_cmd(make_cmd(clni_pkg::CMD_CLEAR, 8'h00, 7'h00, 3'd0, 1'b0));
    send_cmd(make_cmd(clni_pkg::CMD_BLINK, 8'h00, 7'h00, 3'd0, 1'b1));
    send_cmd(make_cmd(clni_pkg::CMD_CURSOR, 8'h00, 7'h00, 3'd0, 1'b1));
    send_cmd(make_cmd(clni_pkg::CMD_BLINK, 8'hFF, 7'h7F, 3'd7, 1'b0));
    send_cmd(make_cmd(clni_pkg::CMD_CURSOR, 8'hFF, 7'h7F, 3'd7, 1'b0));
    // undefined commands produce no beats at all
    send_cmd(make_cmd(CMD_UNDEF_6, 8'hFF, 7'h7F, 3'd7, 1'b1));
    send_cmd(make_cmd(CMD_UNDEF_7, 8'h00, 7'h00, 3'd0, 1'b0));
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'h00, 3'd0, 1'b0));
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'h7F, 3'd7, 1'b0));
    // row past the last row falls back to zero
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'd15, 3'd3, 1'b0));
    // column overflow folds into the next row
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'd31, 3'd0, 1'b0));
  endtask

  task automatic test_line_wrap();
    // last row wraps back to row zero
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'd14, 3'd1, 1'b0));
    repeat (3) begin
      send_cmd(make_cmd(clni_pkg::CMD_PRINT, 8'($urandom_range(255)), 7'h00, 3'd0, 1'b0));
    end
    // first row wraps to the second
    send_cmd(make_cmd(clni_pkg::CMD_GOTO, 8'h00, 7'd15, 3'd0, 1'b0));
    repeat (2) begin
      send_cmd(make_cmd(clni_pkg::CMD_PRINT, 8'($urandom_range(255)), 7'h00, 3'd0, 1'b0));
    end
  endtask

  task automatic test_config_sweep();
    logic [5:0]         col_set [6];
    logic [2:0]         row_set [6];
    clni_pkg::in_item_t it;
    int                 n;
    col_set = '{6'd0, 6'd40, 6'd63, 6'd1, 6'd5, 6'd16};
    row_set = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd3, 3'd2};
    col_set[5] = 6'($urandom_range(1, 12));
    row_set[5] = 3'($urandom_range(7));
    for (int s = 0; s < 6; s++) begin
      drain_beats();
      write_cfg(clni_pkg::CFG_COLUMNS, col_set[s]);
      write_cfg(clni_pkg::CFG_ROWS, {3'($urandom_range(7)), row_set[s]});
      gaps_on = (s != 2);
      send_cmd(make_cmd(clni_pkg::CMD_INIT, 8'($urandom_range(255)), 7'($urandom_range(127)),
                        3'($urandom_range(7)), 1'($urandom_range(1))));
      n = 1;
      while (n < SEG_ITEMS) begin
        it = random_cmd();
        send_cmd(it);
        if (it.cmd inside {clni_pkg::CMD_PRINT, clni_pkg::CMD_GOTO, clni_pkg::CMD_CLEAR,
                           clni_pkg::CMD_BLINK, clni_pkg::CMD_CURSOR, clni_pkg::CMD_INIT})
          n++;
        // hold off mid-segment until the bus has caught up
        if (s == 4 && n == SEG_ITEMS / 2) drain_beats();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = clni_pkg::CFG_COLUMNS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    gaps_on   = 1'b1;
    errors        = 0;
    cmds_sent     = 0;
    beats_checked = 0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    cols_reg  = clni_pkg::COLS_RESET;
    rows_reg  = clni_pkg::ROWS_RESET;
    cur_col   = '0;
    cur_row   = '0;
    disp_ctrl = clni_pkg::LCD_DISP_DEFAULT;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_init_sequence();
    test_basic_commands();
    test_line_wrap();
    test_config_sweep();

    drain_beats();
    $display("tb: %0d commands sent, %0d nibble beats checked, %0d register writes",
             cmds_sent, beats_checked, cfg_writes);
    $display("tb: columns 0..63 and rows 0..7 swept, wraps and goto folding exercised");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
